>>> design/asd_pkg.sv
`timescale 1ns / 1ps
// asd_pkg: shared types and constants for the accelerometer shake detector
// no dependencies

package asd_pkg;

   localparam int AxisWidth  = 16;
   localparam int TimeWidth  = 32;
   localparam int MagWidth   = 16;
   localparam int LevelWidth = 11;
   localparam int ThrWidth   = 15;
   localparam int TrigWidth  = 4;
   localparam int MsWidth    = 16;
   localparam int CsrAddrWidth = 2;

   localparam logic [TimeWidth-1:0] HoldMs = 32'd500;
   localparam logic [LevelWidth-1:0] LevelFull = 11'd1024;

   localparam logic [CsrAddrWidth-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_TRIGGER   = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_WINDOW    = 2'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_COOLDOWN  = 2'd3;

   // queue entry between front and back
   typedef struct packed {
      logic [31:0]          sumsq;
      logic [TimeWidth-1:0] time_ms;
   } sample_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_EVAL,
      ST_DIV,
      ST_DECAY,
      ST_OUT
   } back_state_type;

endpackage

>>> design/accel_shake_detector.sv
`timescale 1ns / 1ps
// accel_shake_detector: top level, configuration registers and channel wiring
// depends on asd_pkg, asd_front, asd_back
//
// usage:
//   req channel carries one accelerometer sample per transaction; rsp channel
//   returns exactly one result per sample in order. csr channel writes the
//   four configuration registers; the user must write them only while the
//   block is idle, which the block itself does not enforce.
//   after a req the axes are squared and summed into the queue; the back
//   picks the sample up, runs the square root steps, an evaluation state,
//   the divide steps, a decay state and an output state, then rsp_tvalid
//   rises. the back takes the next sample only after its output state.
//   the front stage squares and sums the axes and holds up to two samples in
//   a queue, so it keeps taking samples while the back is busy.
//   reset clears detection state and restores default register values.
//   when rsp_tready is low the result is held in its output register and the
//   back sequencer waits; the front queue then fills and req_tready drops.

module accel_shake_detector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // accel_x, accel_y, accel_z, time_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // shake_event, shaking, intensity, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import asd_pkg::*;

   logic [14:0] thr_ff;
   logic [3:0]  trig_ff;
   logic [15:0] win_ff, cool_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= 15'd3840;
         trig_ff <= 4'd3;
         win_ff  <= 16'd500;
         cool_ff <= 16'd2000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD: thr_ff  <= csr_data[14:0];
            CSR_TRIGGER:   trig_ff <= csr_data[3:0];
            CSR_WINDOW:    win_ff  <= csr_data;
            CSR_COOLDOWN:  cool_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic       q_valid, q_ready;
   sample_type q_data;
   logic [12:0] out_data;

   asd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .ax       (req_tdata[15:0]),
      .ay       (req_tdata[31:16]),
      .az       (req_tdata[47:32]),
      .tm       (req_tdata[79:48]),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_data   (q_data)
   );

   asd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .thr       (thr_ff),
      .trig      (trig_ff),
      .win       (win_ff),
      .cool      (cool_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {3'b000, out_data};

endmodule

>>> design/asd_front.sv
`timescale 1ns / 1ps
// asd_front: accepts samples, squares and sums the axes into a two-entry queue
// depends on asd_pkg

module asd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [15:0]            ax,
   input  logic [15:0]            ay,
   input  logic [15:0]            az,
   input  logic [31:0]            tm,
   output logic                   q_valid,
   input  logic                   q_ready,
   output asd_pkg::sample_type    q_data
);
   import asd_pkg::*;

   // stage 1: squares registered
   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [31:0] s1_time_ff;
   // two entry queue
   sample_type  q_mem_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff, count_in;
   logic        push, pop, s1_ready;

   assign pop      = q_valid && q_ready;
   assign push     = s1_valid_ff && (count_ff != 2'd2);
   assign s1_ready = !s1_valid_ff || push;
   assign in_ready = s1_ready;
   assign s1_valid_in = (in_valid && in_ready) || (s1_valid_ff && !push);
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};
   assign q_valid  = count_ff != 2'd0;
   assign q_data   = q_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         count_ff    <= 2'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         count_ff    <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sq_x_ff    <= 32'($signed(ax) * $signed(ax));
         sq_y_ff    <= 32'($signed(ay) * $signed(ay));
         sq_z_ff    <= 32'($signed(az) * $signed(az));
         s1_time_ff <= tm;
      end
      if (push) begin
         q_mem_ff[wr_ptr_ff].sumsq   <= sq_x_ff + sq_y_ff + sq_z_ff;
         q_mem_ff[wr_ptr_ff].time_ms <= s1_time_ff;
      end
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 |-> !pop) else $error("pop from empty queue");
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && count_ff == 2'd2 && !pop |=> s1_valid_ff)
      else $error("stage lost a sample");
`endif

endmodule

>>> design/asd_back.sv
`timescale 1ns / 1ps
// asd_back: square root, detection state, intensity divide and decay
// depends on asd_pkg

module asd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  asd_pkg::sample_type    q_data,
   input  logic [14:0]            thr,
   input  logic [3:0]             trig,
   input  logic [15:0]            win,
   input  logic [15:0]            cool,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [12:0]            out_data
);
   import asd_pkg::*;

   back_state_type state_ff, state_in;

   logic [31:0] rem_ff, root_ff;
   logic [4:0]  step_ff;
   logic [31:0] now_ff;
   logic [15:0] mag_ff;

   logic [15:0] prev_mag_ff;
   logic [3:0]  count_ff;
   logic [31:0] peak_ff, wstart_ff, shake_ff;
   logic        shaking_ff, rising_ff, event_ff, cool_ff;
   logic [10:0] level_ff;

   logic [26:0] dividend_ff;
   logic [16:0] divisor_ff;
   logic [10:0] quot_ff;
   logic [16:0] drem_ff;

   logic        out_valid_ff;
   logic [12:0] out_data_ff;

   // combinational square root step
   logic [31:0] sq_bit, sq_trial;
   assign sq_bit   = 32'd1 << {step_ff, 1'b0};
   assign sq_trial = root_ff + sq_bit;

   // eval combinational
   logic [16:0] delta;
   logic        dir, delta_neg;
   logic [15:0] absd;
   logic [19:0] absd10;
   logic [16:0] thr3;
   logic        rev_hit;
   logic [31:0] dt_shake;
   assign delta     = {1'b0, mag_ff} - {1'b0, prev_mag_ff};
   assign delta_neg = delta[16];
   assign dir       = !delta_neg && (delta != 17'd0);
   assign absd      = delta_neg ? 16'(-delta) : delta[15:0];
   assign absd10    = {absd, 3'b000} + {3'b000, absd, 1'b0};
   assign thr3      = {2'b00, thr} + {1'b0, thr, 1'b0};
   assign rev_hit   = (absd10 > {3'b000, thr3}) && (dir != rising_ff);
   assign dt_shake  = now_ff - shake_ff;

   // divide step
   logic [17:0] dtrial;
   assign dtrial = {drem_ff, dividend_ff[26]} - {1'b0, divisor_ff};

   logic sq_done;
   assign sq_done = step_ff == 5'd0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (q_valid) state_in = ST_SQRT;
         ST_SQRT:  if (sq_done) state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_DIV;
         ST_DIV:   if (step_ff == 5'd0) state_in = ST_DECAY;
         ST_DECAY: state_in = ST_OUT;
         ST_OUT:   if (!out_valid_ff || out_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_ready = state_ff == ST_IDLE;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         prev_mag_ff  <= '0;
         count_ff     <= '0;
         peak_ff      <= '0;
         wstart_ff    <= '0;
         shake_ff     <= '0;
         shaking_ff   <= 1'b0;
         rising_ff    <= 1'b0;
         level_ff     <= '0;
         event_ff     <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && (!out_valid_ff || out_ready)) out_valid_ff <= 1'b1;
         else if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (q_valid) begin
               rem_ff   <= q_data.sumsq;
               root_ff  <= '0;
               step_ff  <= 5'd15;
               now_ff   <= q_data.time_ms;
               event_ff <= 1'b0;
            end
            ST_SQRT: begin
               if (rem_ff >= sq_trial) begin
                  rem_ff  <= rem_ff - sq_trial;
                  root_ff <= (root_ff >> 1) + sq_bit;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               if (sq_done) mag_ff <= 16'((rem_ff >= sq_trial) ? (root_ff >> 1) + sq_bit
                                                               : root_ff >> 1);
               else step_ff <= step_ff - 5'd1;
            end
            ST_EVAL: begin
               cool_ff     <= dt_shake < {16'd0, cool};
               prev_mag_ff <= mag_ff;
               dividend_ff <= {1'b0, mag_ff, 10'd0};
               divisor_ff  <= thr3;
               drem_ff     <= '0;
               quot_ff     <= '0;
               step_ff     <= 5'd26;
               if (!(dt_shake < {16'd0, cool})) begin : norm
                  logic [3:0]  c;
                  logic [31:0] ws, pk;
                  logic        sh;
                  c = count_ff; ws = wstart_ff; pk = peak_ff; sh = shaking_ff;
                  if (rev_hit) begin
                     if (mag_ff > {1'b0, thr}) begin
                        if (c == 4'd0) ws = now_ff;
                        if ((now_ff - ws) < {16'd0, win}) begin
                           if (c != 4'd15) c = c + 4'd1;
                           pk = now_ff;
                           if (c >= trig) begin
                              if (!sh) begin
                                 sh = 1'b1;
                                 shake_ff <= now_ff;
                                 event_ff <= 1'b1;
                              end
                              c = 4'd0;
                           end
                        end else begin
                           c = 4'd1;
                           ws = now_ff;
                        end
                     end
                     rising_ff <= dir;
                  end
                  if ((now_ff - pk) > {15'd0, win, 1'b0}) c = 4'd0;
                  count_ff   <= c;
                  wstart_ff  <= ws;
                  peak_ff    <= pk;
                  shaking_ff <= sh;
               end
            end
            ST_DIV: begin
               // restoring divide of mag*1024 by 3*thr, 11-bit saturating quotient
               if (!dtrial[17]) begin
                  drem_ff <= dtrial[16:0];
                  if (quot_ff[10] == 1'b0) quot_ff <= {quot_ff[9:0], 1'b1};
                  else quot_ff <= 11'h7FF;
               end else begin
                  drem_ff <= {drem_ff[15:0], dividend_ff[26]};
                  if (quot_ff[10] == 1'b0) quot_ff <= {quot_ff[9:0], 1'b0};
                  else quot_ff <= 11'h7FF;
               end
               dividend_ff <= {dividend_ff[25:0], 1'b0};
               if (step_ff != 5'd0) step_ff <= step_ff - 5'd1;
            end
            ST_DECAY: begin : dec
               logic [10:0] lv;
               logic        sh;
               lv = level_ff; sh = shaking_ff;
               if (event_ff) begin
                  if (divisor_ff == 17'd0 || quot_ff >= LevelFull) lv = LevelFull;
                  else lv = quot_ff;
               end
               if ((cool_ff && sh) ||
                   (!cool_ff && sh && dt_shake > HoldMs)) begin
                  lv = 11'(({11'd0, lv} * (cool_ff ? 22'd973 : 22'd922)) >> 10);
                  if ({lv, 3'b000} + {2'b00, lv, 1'b0} < 14'd1024) begin
                     lv = '0; sh = 1'b0;
                  end
               end
               level_ff   <= lv;
               shaking_ff <= sh;
            end
            ST_OUT: if (!out_valid_ff || out_ready) begin
               out_data_ff  <= {level_ff, shaking_ff, event_ff};
            end
            default: ;
         endcase
      end
   end

`ifndef SYNTH
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LevelFull) else $error("intensity out of range");
   a_idle_level: assert property (@(posedge clock) disable iff (reset)
      !shaking_ff |-> level_ff == 11'd0 || state_ff == ST_DECAY || state_ff == ST_OUT
      || state_ff == ST_DIV || state_ff == ST_EVAL)
      else $error("intensity without shake");
   a_event_shake: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff[0] |-> out_data_ff[1]) else $error("event without flag");
`endif

endmodule

>>> dv/asd_checker.sv
`timescale 1ns / 1ps
// asd_checker: watches the csr, req and rsp channels of the shake detector,
// predicts each result from the accepted samples and compares it field by field
// depends on asd_pkg

module asd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          pending,
   output int          fail_count
);
   import asd_pkg::*;

   typedef struct {
      logic                  shake_event;
      logic                  shaking;
      logic [LevelWidth-1:0] intensity;
   } shake_result_type;

   shake_result_type expected_results[$];

   logic [ThrWidth-1:0]  threshold;
   logic [TrigWidth-1:0] trigger;
   logic [MsWidth-1:0]   window;
   logic [MsWidth-1:0]   cooldown;

   logic [MagWidth-1:0]  prev_mag;
   logic [3:0]           rev_count;
   logic [31:0]          peak_ms;
   logic [31:0]          win_start;
   logic [31:0]          shake_ms;
   logic                 shaking_st;
   logic [31:0]          level;
   logic                 rising;

   assign pending = expected_results.size();

   function automatic logic [31:0] floor_sqrt(input logic [31:0] n);
      logic [31:0] root;
      logic [31:0] bitv;
      root = 0;
      bitv = 32'h4000_0000;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   task automatic fade(input logic [31:0] factor);
      level = (level * factor) >> 10;
      if (level * 10 < 1024) begin
         shaking_st = 1'b0;
         level = 0;
      end
   endtask

   task automatic predict_sample(input logic [79:0] d);
      logic signed [15:0] ax, ay, az;
      int xi, yi, zi;
      logic [31:0] now, sumsq, mag, absd, full, q, lvl;
      int delta;
      logic dir;
      shake_result_type r;
      ax = d[15:0];
      ay = d[31:16];
      az = d[47:32];
      now = d[79:48];
      xi = ax;
      yi = ay;
      zi = az;
      sumsq = 32'(xi * xi) + 32'(yi * yi) + 32'(zi * zi);
      mag = floor_sqrt(sumsq);
      delta = int'(mag) - int'(prev_mag);
      r.shake_event = 1'b0;
      if (32'(now - shake_ms) < 32'(cooldown)) begin
         prev_mag = mag[15:0];
         if (shaking_st) fade(32'd973);
      end else begin
         dir = delta > 0;
         absd = delta < 0 ? 32'(-delta) : 32'(delta);
         if (10 * absd > 3 * 32'(threshold) && dir != rising) begin
            if (mag > 32'(threshold)) begin
               if (rev_count == 0) win_start = now;
               if (32'(now - win_start) < 32'(window)) begin
                  if (rev_count < 15) rev_count = rev_count + 1;
                  peak_ms = now;
                  if (rev_count >= trigger) begin
                     if (!shaking_st) begin
                        full = 3 * 32'(threshold);
                        lvl = 1024;
                        shaking_st = 1'b1;
                        shake_ms = now;
                        if (full != 0) begin
                           q = (mag << 10) / full;
                           if (q < lvl) lvl = q;
                        end
                        level = lvl;
                        r.shake_event = 1'b1;
                     end
                     rev_count = 0;
                  end
               end else begin
                  rev_count = 1;
                  win_start = now;
               end
            end
            rising = dir;
         end
         if (32'(now - peak_ms) > 2 * 32'(window)) rev_count = 0;
         if (shaking_st && 32'(now - shake_ms) > HoldMs) fade(32'd922);
         prev_mag = mag[15:0];
      end
      r.shaking = shaking_st;
      r.intensity = level[LevelWidth-1:0];
      expected_results.push_back(r);
   endtask

   always @(posedge clock) begin
      shake_result_type e;
      if (reset) begin
         threshold <= 15'd3840;
         trigger <= 4'd3;
         window <= 16'd500;
         cooldown <= 16'd2000;
         prev_mag = 0;
         rev_count = 0;
         peak_ms = 0;
         win_start = 0;
         shake_ms = 0;
         shaking_st = 0;
         level = 0;
         rising = 0;
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD: threshold <= csr_data[ThrWidth-1:0];
               CSR_TRIGGER:   trigger <= csr_data[TrigWidth-1:0];
               CSR_WINDOW:    window <= csr_data;
               CSR_COOLDOWN:  cooldown <= csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected rsp transaction %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_results.pop_front();
               if (rsp_tdata[0] !== e.shake_event || rsp_tdata[1] !== e.shaking
                   || rsp_tdata[12:2] !== e.intensity) begin
                  if (rsp_tdata[0] !== e.shake_event)
                     $error("shake_event expected %0d actual %0d", e.shake_event,
                            rsp_tdata[0]);
                  if (rsp_tdata[1] !== e.shaking)
                     $error("shaking expected %0d actual %0d", e.shaking, rsp_tdata[1]);
                  if (rsp_tdata[12:2] !== e.intensity)
                     $error("intensity expected %0d actual %0d", e.intensity,
                            rsp_tdata[12:2]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for accel_shake_detector
// depends on asd_pkg, accel_shake_detector and asd_checker

module tb;
   import asd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;  // accel_x, accel_y, accel_z, time_ms
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;  // shake_event, shaking, intensity, zero pad
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;
   int          pending;
   int          fail_count;

   logic        calm;
   int          hold_off;
   logic [31:0] tnow;
   int          sent;
   int          idle_cycles;

   accel_shake_detector dut (.*);

   asd_checker chk (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // receiver side: random stall bursts, one long hold-off on request
   initial begin
      int n;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_tready = 0;
            repeat (hold_off - 1) @(negedge clock);
            hold_off = 0;
         end else if (calm) begin
            rsp_tready = 1;
         end else begin
            n = $urandom_range(1, 18);
            rsp_tready = ($urandom_range(0, 3) != 0);
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // watchdog on cycles with no transaction at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                              input logic [15:0] az, input logic [31:0] t);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_tvalid = 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1;
      req_tdata = {t, az, ay, ax};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic write_all(input logic [15:0] thr, input logic [15:0] trg,
                            input logic [15:0] win, input logic [15:0] cd);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_TRIGGER, trg);
      write_reg(CSR_WINDOW, win);
      write_reg(CSR_COOLDOWN, cd);
   endtask

   function automatic logic [15:0] sgn(input int v);
      return ($urandom_range(0, 1) != 0) ? 16'(-v) : 16'(v);
   endfunction

   // alternating high and low magnitudes with short time steps
   task automatic shake_burst(input int n);
      for (int i = 0; i < n; i++) begin
         tnow = tnow + $urandom_range(1, 60);
         if (i % 2 == 0)
            send_sample(sgn($urandom_range(6000, 32768)), sgn($urandom_range(0, 4000)),
                        sgn($urandom_range(0, 4000)), tnow);
         else
            send_sample(sgn($urandom_range(0, 300)), sgn($urandom_range(0, 300)),
                        sgn($urandom_range(0, 300)), tnow);
      end
   endtask

   task automatic noise_sample();
      tnow = ($urandom_range(0, 7) == 0) ? $urandom : tnow + $urandom_range(0, 3000);
      send_sample(16'($urandom), 16'($urandom), 16'($urandom), tnow);
   endtask

   task automatic random_part(input int quota);
      int start;
      start = sent;
      while (sent - start < quota) begin
         if ($urandom_range(0, 9) < 7) shake_burst($urandom_range(4, 12));
         else noise_sample();
      end
   endtask

   initial begin
      calm = 0;
      hold_off = 0;
      sent = 0;
      tnow = 0;
      req_tvalid = 0;
      req_tdata = 0;
      csr_valid = 0;
      csr_index = CSR_THRESHOLD;
      csr_data = 0;
      reset = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: axis extremes under reset defaults
      send_sample(16'h8000, 16'h8000, 16'h8000, 32'd0);
      send_sample(16'h7fff, 16'h7fff, 16'h7fff, 32'd10);
      send_sample(16'h0000, 16'h0000, 16'h0000, 32'd20);
      send_sample(16'h8000, 16'h0000, 16'h0000, 32'd30);
      send_sample(16'h0001, 16'hffff, 16'h0000, 32'd40);
      tnow = 32'd50;
      shake_burst(8);
      tnow = 32'hffff_ff00;
      shake_burst(8);
      drain();
      // zero threshold, excess bit set, trigger of zero
      write_all(16'h8000, 16'h0000, 16'd300, 16'd0);
      shake_burst(6);
      drain();

      write_all(16'd3840, 16'd1, 16'd65535, 16'd65535);
      hold_off = 400;
      random_part(250);
      drain();
      write_all(16'h7fff, 16'd15, 16'd0, 16'd0);
      random_part(200);
      drain();
      write_all(16'd2000, 16'd2, 16'd400, 16'd100);
      random_part(300);
      drain();
      write_all(16'd0, 16'hfff1, 16'hffff, 16'd1000);
      random_part(250);
      drain();
      write_all(16'd3840, 16'd3, 16'd500, 16'd2000);
      random_part(300);
      drain();
      calm = 1;
      write_all(16'd1500, 16'd2, 16'd800, 16'd300);
      random_part(300);
      drain();

      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
design/asd_pkg.sv
design/asd_front.sv
design/asd_back.sv
design/accel_shake_detector.sv
dv/asd_checker.sv
dv/tb.sv
